### sv/sret_pkg.sv
package sret_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int COORD_W   = 10;
  localparam int DIM_W     = 11;
  localparam int SOB_THR_W = 11;
  localparam int ROB_THR_W = 9;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int DIM_LIMIT   = 1024;
  localparam int MIN_DIM     = 3;
  localparam int WIDTH_LIMIT = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;

  localparam int LINE_AW     = $clog2(WIDTH_LIMIT);
  localparam int LINE_WORD_W = 2 * PIXEL_BITS;

  localparam int SOB_MAG_W = PIXEL_BITS + 2;
  localparam int ROB_MAG_W = PIXEL_BITS;
  localparam int SOB_SQ_W  = 2 * SOB_THR_W;
  localparam int ROB_SQ_W  = 2 * ROB_THR_W;

  localparam int RST_WIDTH   = 640;
  localparam int RST_HEIGHT  = 480;
  localparam int RST_SOB_THR = 200;
  localparam int RST_ROB_THR = 40;

  localparam logic [PIXEL_BITS-1:0] EDGE_ON  = '1;
  localparam logic [PIXEL_BITS-1:0] EDGE_OFF = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_SOBEL_THR     = 2'd2,
    CFG_ROBERTS_THR   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] luma;
    logic                  frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0]    out_row;
    logic [COORD_W-1:0]    out_col;
    logic [PIXEL_BITS-1:0] edge_value;
    logic                  frame_done;
  } out_beat_t;

  typedef struct packed {
    logic [SOB_MAG_W-1:0] gx_mag;
    logic [SOB_MAG_W-1:0] gy_mag;
    logic [ROB_MAG_W-1:0] rx_mag;
    logic [ROB_MAG_W-1:0] ry_mag;
  } grad_t;

endpackage

### sv/sret_line_buf.sv
module sret_line_buf (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [sret_pkg::LINE_AW-1:0]      rd_addr,
  output logic [sret_pkg::LINE_WORD_W-1:0]  rd_data,
  input  logic                              wr_en,
  input  logic [sret_pkg::LINE_AW-1:0]      wr_addr,
  input  logic [sret_pkg::LINE_WORD_W-1:0]  wr_data
);
  import sret_pkg::*;

  logic [LINE_WORD_W-1:0] mem [WIDTH_LIMIT];
  logic [LINE_WORD_W-1:0] rd_q_r;
  logic [LINE_WORD_W-1:0] byp_data_r;
  logic                   byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // forward a write that lands on the address being read in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

### sv/sret_window.sv
module sret_window (
  input  logic                             clk,
  input  logic                             shift_en,
  input  logic [sret_pkg::PIXEL_BITS-1:0]  up_pix,
  input  logic [sret_pkg::PIXEL_BITS-1:0]  lo_pix,
  input  logic [sret_pkg::PIXEL_BITS-1:0]  new_pix,
  input  logic                             grad_en,
  output sret_pkg::grad_t                  grad
);
  import sret_pkg::*;

  logic [PIXEL_BITS-1:0] win_r [3][3];
  grad_t                 grad_r;
  grad_t                 grad_nxt;
  logic [SOB_MAG_W-1:0]  xp, xn, yp, yn;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int a = 0; a < 3; a++) begin
        win_r[a][0] <= win_r[a][1];
        win_r[a][1] <= win_r[a][2];
      end
      win_r[0][2] <= up_pix;
      win_r[1][2] <= lo_pix;
      win_r[2][2] <= new_pix;
    end
  end

  always_comb begin
    xp = SOB_MAG_W'(win_r[0][2]) + SOB_MAG_W'({win_r[1][2], 1'b0}) + SOB_MAG_W'(win_r[2][2]);
    xn = SOB_MAG_W'(win_r[0][0]) + SOB_MAG_W'({win_r[1][0], 1'b0}) + SOB_MAG_W'(win_r[2][0]);
    yp = SOB_MAG_W'(win_r[2][0]) + SOB_MAG_W'({win_r[2][1], 1'b0}) + SOB_MAG_W'(win_r[2][2]);
    yn = SOB_MAG_W'(win_r[0][0]) + SOB_MAG_W'({win_r[0][1], 1'b0}) + SOB_MAG_W'(win_r[0][2]);
    grad_nxt.gx_mag = (xp >= xn) ? xp - xn : xn - xp;
    grad_nxt.gy_mag = (yp >= yn) ? yp - yn : yn - yp;
    grad_nxt.rx_mag = (win_r[1][1] >= win_r[0][0]) ? win_r[1][1] - win_r[0][0]
                                                    : win_r[0][0] - win_r[1][1];
    grad_nxt.ry_mag = (win_r[1][0] >= win_r[0][1]) ? win_r[1][0] - win_r[0][1]
                                                    : win_r[0][1] - win_r[1][0];
  end

  always_ff @(posedge clk) begin
    if (grad_en) begin
      grad_r <= grad_nxt;
    end
  end

  assign grad = grad_r;

endmodule

### sv/sret_edge_cmp.sv
module sret_edge_cmp (
  input  sret_pkg::grad_t                  grad,
  input  logic [sret_pkg::SOB_SQ_W-1:0]    sob_sq,
  input  logic [sret_pkg::ROB_SQ_W-1:0]    rob_sq,
  output logic                             is_edge
);
  import sret_pkg::*;

  logic [2*SOB_MAG_W-1:0] gx_sq, gy_sq;
  logic [2*ROB_MAG_W-1:0] rx_sq, ry_sq;
  logic [2*SOB_MAG_W:0]   sob_sum;
  logic [2*ROB_MAG_W:0]   rob_sum;

  always_comb begin
    gx_sq   = grad.gx_mag * grad.gx_mag;
    gy_sq   = grad.gy_mag * grad.gy_mag;
    rx_sq   = grad.rx_mag * grad.rx_mag;
    ry_sq   = grad.ry_mag * grad.ry_mag;
    sob_sum = {1'b0, gx_sq} + {1'b0, gy_sq};
    rob_sum = {1'b0, rx_sq} + {1'b0, ry_sq};
    is_edge = (SOB_SQ_W'(sob_sum) > sob_sq) && (ROB_SQ_W'(rob_sum) > rob_sq);
  end

endmodule

### sv/sobel_roberts_edge_threshold.sv
// Streaming 3x3 Sobel plus 2x2 Roberts-cross edge detector.
// Input channel in_valid/in_ready/in_data carries one luma pixel per beat in
// raster order; frame_start forces the position to row 0, column 0.
// Result channel out_valid/out_ready/out_data carries one beat for each pixel
// at row >= 1 and column >= 1, describing centre (row-1, col-1): 255 when
// both squared gradient magnitudes exceed the squared thresholds, else 0.
// Centres in row 0 or column 0 give 0; frame_done marks the frame's last beat.
// Pipeline: input register with line store read, window, gradients, output
// register. Throughput is one pixel per cycle unless the receiver stalls,
// set by the single line store port pair. Pixels that produce no result
// leave a bubble in the result stream, not a beat.
// When the receiver stalls, stages fill up one by one; in_ready drops only
// once the input register cannot move on, so up to four beats are held.
// Reset clears position, pipeline valids and loads width 640, height 480,
// thresholds 200 and 40. Line stores have no reset; no clearing pass runs.
// cfg_wr_en writes cfg_wdata to register cfg_index with no wait.
module sobel_roberts_edge_threshold (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sret_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sret_pkg::out_beat_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [sret_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sret_pkg::CFG_W-1:0]      cfg_wdata
);
  import sret_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int hi);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(MIN_DIM)) begin
      res = DIM_W'(MIN_DIM);
    end else if (v > DIM_W'(hi)) begin
      res = DIM_W'(hi);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // configuration, held as last index and squared thresholds
  logic [COORD_W-1:0]  last_col_r, last_row_r;
  logic [SOB_SQ_W-1:0] sob_sq_r;
  logic [ROB_SQ_W-1:0] rob_sq_r;
  logic [DIM_W-1:0]    dim_w, dim_h;

  assign dim_w = clamp_dim(cfg_wdata, WIDTH_LIMIT);
  assign dim_h = clamp_dim(cfg_wdata, DIM_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= COORD_W'(RST_WIDTH - 1);
      last_row_r <= COORD_W'(RST_HEIGHT - 1);
      sob_sq_r   <= SOB_SQ_W'(RST_SOB_THR * RST_SOB_THR);
      rob_sq_r   <= ROB_SQ_W'(RST_ROB_THR * RST_ROB_THR);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  last_col_r <= COORD_W'(dim_w - DIM_W'(1));
        CFG_IMAGE_HEIGHT: last_row_r <= COORD_W'(dim_h - DIM_W'(1));
        CFG_SOBEL_THR:    sob_sq_r   <= SOB_SQ_W'(cfg_wdata * cfg_wdata);
        CFG_ROBERTS_THR:  rob_sq_r   <= ROB_SQ_W'(cfg_wdata[ROB_THR_W-1:0] *
                                                  cfg_wdata[ROB_THR_W-1:0]);
      endcase
    end
  end

  // handshake chain
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic out_free, s3_free, s2_free;
  logic s3_adv, s2_adv, s1_adv, accept;

  assign out_free = !out_valid_r || out_ready;
  assign s3_adv   = s3_valid_r && out_free;
  assign s3_free  = !s3_valid_r || out_free;
  assign s2_adv   = s2_valid_r && s3_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;
  assign accept   = in_valid && in_ready;

  // position of the arriving pixel
  logic [COORD_W-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [COORD_W-1:0] pos_row, pos_col;
  logic [DIM_W-1:0]   row_tmp;
  logic [COORD_W-1:0] col_tmp;

  always_comb begin
    row_tmp = in_data.frame_start ? '0 : DIM_W'(row_r);
    col_tmp = in_data.frame_start ? '0 : col_r;
    if (col_tmp > last_col_r) begin
      col_tmp = '0;
      row_tmp = row_tmp + DIM_W'(1);
    end
    pos_row = (row_tmp > DIM_W'(last_row_r)) ? '0 : COORD_W'(row_tmp);
    pos_col = col_tmp;
    if (pos_col == last_col_r) begin
      col_nxt = '0;
      row_nxt = (pos_row == last_row_r) ? '0 : pos_row + COORD_W'(1);
    end else begin
      col_nxt = pos_col + COORD_W'(1);
      row_nxt = pos_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage 1: input register, line store data arrives alongside
  logic [PIXEL_BITS-1:0]  s1_pix_r;
  logic [COORD_W-1:0]     s1_row_r, s1_col_r;
  logic [LINE_WORD_W-1:0] line_rd;
  logic [PIXEL_BITS-1:0]  up_pix, lo_pix;
  logic                   s1_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_data.luma;
      s1_row_r <= pos_row;
      s1_col_r <= pos_col;
    end
  end

  sret_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pos_col[LINE_AW-1:0]),
    .rd_data (line_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r[LINE_AW-1:0]),
    .wr_data ({lo_pix, s1_pix_r})
  );

  assign up_pix  = line_rd[LINE_WORD_W-1:PIXEL_BITS];
  assign lo_pix  = line_rd[PIXEL_BITS-1:0];
  assign s1_emit = (s1_row_r != '0) && (s1_col_r != '0);

  // stage 2: window holds this centre; stage 3: gradients
  logic [COORD_W-1:0] s2_row_r, s2_col_r, s3_row_r, s3_col_r;
  logic               s2_border_r, s2_done_r, s3_border_r, s3_done_r;
  grad_t              grad;
  logic               is_edge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s2_valid_r <= s1_emit;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s3_free) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_row_r    <= s1_row_r - COORD_W'(1);
      s2_col_r    <= s1_col_r - COORD_W'(1);
      s2_border_r <= (s1_row_r == COORD_W'(1)) || (s1_col_r == COORD_W'(1));
      s2_done_r   <= (s1_row_r == last_row_r) && (s1_col_r == last_col_r);
    end
    if (s2_adv) begin
      s3_row_r    <= s2_row_r;
      s3_col_r    <= s2_col_r;
      s3_border_r <= s2_border_r;
      s3_done_r   <= s2_done_r;
    end
  end

  sret_window u_window (
    .clk      (clk),
    .shift_en (s1_adv),
    .up_pix   (up_pix),
    .lo_pix   (lo_pix),
    .new_pix  (s1_pix_r),
    .grad_en  (s2_adv),
    .grad     (grad)
  );

  sret_edge_cmp u_edge_cmp (
    .grad    (grad),
    .sob_sq  (sob_sq_r),
    .rob_sq  (rob_sq_r),
    .is_edge (is_edge)
  );

  // output register
  out_beat_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      out_data_r.out_row    <= s3_row_r;
      out_data_r.out_col    <= s3_col_r;
      out_data_r.edge_value <= (is_edge && !s3_border_r) ? EDGE_ON : EDGE_OFF;
      out_data_r.frame_done <= s3_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ready_only_blocked_by_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s2_valid_r)
    else $error("input stalled without a full input register");

  a_border_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s3_adv && s3_border_r |=> out_data_r.edge_value == EDGE_OFF)
    else $error("border centre produced an edge");

  a_edge_encoding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.edge_value == EDGE_ON || out_data_r.edge_value == EDGE_OFF)
    else $error("edge value neither on nor off");

  a_non_emit_leaves_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_emit |=> !s2_valid_r)
    else $error("pixel without a centre entered the result pipeline");

endmodule
